[rtl/lcdseq_pkg.sv]
// types, codes and constant tables shared by the lcd bus write sequencer
`default_nettype none

package lcdseq_pkg;

   localparam int BYTE_W    = 8;
   localparam int CMD_W     = 3;
   localparam int COLUMN_W  = 6;
   localparam int CSR_IDX_W = 3;

   // request codes
   localparam logic [CMD_W-1:0] CMD_BYTE   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DATA   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CURSOR = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_INIT   = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FOUR_BIT_BUS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_LINE_BASE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_LINE_BASE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_HIGH_MS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_LOW_MS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_SETUP_MS    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER_ON_MS      = 3'd6;

   localparam logic [BYTE_W-1:0] CLEAR_BYTE = 8'h01;

   // index of the final byte of each init list
   localparam logic [1:0] INIT_LAST_8 = 2'd2;
   localparam logic [1:0] INIT_LAST_4 = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [BYTE_W-1:0]   byte_value;
      logic                row;
      logic [COLUMN_W-1:0] column;
   } req_type;

   typedef struct packed {
      logic              reg_select;
      logic              read_write;
      logic              enable;
      logic [BYTE_W-1:0] data_bus;
      logic [BYTE_W-1:0] hold_ms;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic              four_bit_bus;
      logic [BYTE_W-1:0] first_line_base;
      logic [BYTE_W-1:0] second_line_base;
      logic [BYTE_W-1:0] enable_high_ms;
      logic [BYTE_W-1:0] enable_low_ms;
      logic [BYTE_W-1:0] data_setup_ms;
      logic [BYTE_W-1:0] power_on_ms;
   } cfg_type;

   typedef enum logic [1:0] {
      JOB_CMD,
      JOB_DATA,
      JOB_INIT
   } job_kind_type;

   typedef struct packed {
      job_kind_type      kind;
      logic [BYTE_W-1:0] byte_val;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_head_type;

   function automatic logic [BYTE_W-1:0] init_byte(input logic four_bit, input logic [1:0] idx);
      logic [BYTE_W-1:0] b;
      b = 8'h00;
      if (four_bit) begin
         case (idx)
            2'd0:    b = 8'h02;
            2'd1:    b = 8'h28;
            2'd2:    b = 8'h0C;
            default: b = 8'h06;
         endcase
      end else begin
         case (idx)
            2'd0:    b = 8'h3C;
            2'd1:    b = 8'h0C;
            default: b = 8'h01;
         endcase
      end
      return b;
   endfunction

endpackage

`default_nettype wire

[rtl/lcdseq_front.sv]
// front end: takes requests, drops unknown codes and turns the rest into jobs
`default_nettype none

module lcdseq_front (
   input  wire                   req_valid,
   input  lcdseq_pkg::req_type   req_data,
   output logic                  req_stall,
   input  lcdseq_pkg::cfg_type   cfg,
   input  wire                   queue_full,
   output logic                  push,
   output lcdseq_pkg::job_type   push_job
);

   logic                          accept;
   logic                          known;
   logic [lcdseq_pkg::BYTE_W-1:0] line_base;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign line_base = req_data.row ? cfg.second_line_base : cfg.first_line_base;

   always_comb begin
      known             = 1'b1;
      push_job.kind     = lcdseq_pkg::JOB_CMD;
      push_job.byte_val = req_data.byte_value;
      unique case (req_data.cmd)
         lcdseq_pkg::CMD_BYTE: begin
            push_job.kind = lcdseq_pkg::JOB_CMD;
         end
         lcdseq_pkg::CMD_DATA: begin
            push_job.kind = lcdseq_pkg::JOB_DATA;
         end
         lcdseq_pkg::CMD_CURSOR: begin
            // address wraps at 256
            push_job.byte_val = line_base + {2'b00, req_data.column};
         end
         lcdseq_pkg::CMD_CLEAR: begin
            push_job.byte_val = lcdseq_pkg::CLEAR_BYTE;
         end
         lcdseq_pkg::CMD_INIT: begin
            push_job.kind = lcdseq_pkg::JOB_INIT;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   assign push = accept && known;

endmodule

`default_nettype wire

[rtl/lcdseq_queue.sv]
// short job queue between the front end and the phase generator
`default_nettype none

module lcdseq_queue #(
   parameter int DEPTH = 4
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  lcdseq_pkg::job_type        push_job,
   input  wire                        pop,
   output logic                       full,
   output lcdseq_pkg::queue_head_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lcdseq_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

[rtl/lcdseq_back.sv]
// back end: walks the job at the queue head and emits one bus phase per cycle unless rsp_stall holds the output
`default_nettype none

module lcdseq_back (
   input  wire                        clock,
   input  wire                        reset,
   input  lcdseq_pkg::cfg_type        cfg,
   input  lcdseq_pkg::queue_head_type head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output lcdseq_pkg::rsp_type        rsp_data
);

   logic                          pre_done_ff, pre_done_in;
   logic                          en_lo_ff, en_lo_in;
   logic                          nib_ff, nib_in;
   logic [1:0]                    byte_idx_ff, byte_idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   lcdseq_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic                          emit;
   logic                          prefix;
   logic                          final_byte;
   logic                          final_phase;
   logic [1:0]                    last_idx;
   logic [lcdseq_pkg::BYTE_W-1:0] cur_byte;
   logic [lcdseq_pkg::BYTE_W-1:0] bus_val;
   lcdseq_pkg::rsp_type           phase;

   assign emit   = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign prefix = (head.job.kind != lcdseq_pkg::JOB_CMD) && !pre_done_ff;

   assign last_idx = (head.job.kind != lcdseq_pkg::JOB_INIT) ? 2'd0 :
                     cfg.four_bit_bus ? lcdseq_pkg::INIT_LAST_4 : lcdseq_pkg::INIT_LAST_8;
   assign cur_byte = (head.job.kind == lcdseq_pkg::JOB_INIT) ?
                     lcdseq_pkg::init_byte(cfg.four_bit_bus, byte_idx_ff) : head.job.byte_val;
   assign bus_val  = !cfg.four_bit_bus ? cur_byte :
                     nib_ff ? {4'h0, cur_byte[3:0]} : {4'h0, cur_byte[7:4]};

   assign final_byte  = (byte_idx_ff == last_idx) && (nib_ff || !cfg.four_bit_bus);
   assign final_phase = !prefix && en_lo_ff && final_byte;
   assign pop         = emit && final_phase;

   always_comb begin
      phase.reg_select = (head.job.kind == lcdseq_pkg::JOB_DATA);
      phase.read_write = 1'b0;
      phase.last       = final_phase;
      if (prefix) begin
         phase.enable   = 1'b0;
         phase.data_bus = '0;
         phase.hold_ms  = (head.job.kind == lcdseq_pkg::JOB_DATA) ? cfg.data_setup_ms
                                                                  : cfg.power_on_ms;
      end else begin
         phase.enable   = !en_lo_ff;
         phase.data_bus = bus_val;
         phase.hold_ms  = en_lo_ff ? cfg.enable_low_ms : cfg.enable_high_ms;
      end
   end

   always_comb begin
      pre_done_in = pre_done_ff;
      en_lo_in    = en_lo_ff;
      nib_in      = nib_ff;
      byte_idx_in = byte_idx_ff;
      if (emit) begin
         if (prefix) begin
            pre_done_in = 1'b1;
         end else if (!en_lo_ff) begin
            en_lo_in = 1'b1;
         end else begin
            en_lo_in = 1'b0;
            if (cfg.four_bit_bus && !nib_ff) begin
               nib_in = 1'b1;
            end else begin
               nib_in = 1'b0;
               if (final_byte) begin
                  byte_idx_in = '0;
                  pre_done_in = 1'b0;
               end else begin
                  byte_idx_in = byte_idx_ff + 1'b1;
               end
            end
         end
      end
   end

   // output register parts the queue from the result side
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = phase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_done_ff  <= 1'b0;
         en_lo_ff     <= 1'b0;
         nib_ff       <= 1'b0;
         byte_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pre_done_ff  <= pre_done_in;
         en_lo_ff     <= en_lo_in;
         nib_ff       <= nib_in;
         byte_idx_ff  <= byte_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_last_en_low : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.last) |-> !rsp_data_ff.enable)
      else $error("final phase with enable high");

   a_high_then_low : assert property (@(posedge clock) disable iff (reset)
      (emit && !prefix && !en_lo_ff) |=> en_lo_ff)
      else $error("enable-high phase not followed by enable-low");

   a_nibble_mode : assert property (@(posedge clock) disable iff (reset)
      nib_ff |-> cfg.four_bit_bus)
      else $error("low nibble pending on eight-bit bus");

   a_prefix_not_last : assert property (@(posedge clock) disable iff (reset)
      (emit && prefix) |-> !pop)
      else $error("job retired on its setup phase");

endmodule

`default_nettype wire

[rtl/char_lcd_bus_write_sequencer_core.sv]
// top level of the character lcd bus write sequencer
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   lcdseq_pkg::req_type
//   rsp_      out        rsp_valid/rsp_stall   lcdseq_pkg::rsp_type
//   csr_      in         csr_wr_en             csr_index, csr_wr_data
//
// one bus phase leaves per cycle from the phase generator unless rsp_stall holds it; a request
//   has as many phases as this: 2 or 4 for a byte, 3 or 5 for data, 7 or 17 for init
// requests enter at one per cycle, while the queue is not full, into a job queue of QUEUE_DEPTH entries
// reset loads the register defaults and empties the queue and output register
// rsp_stall holds the output register; req_stall rises only when the queue is full
`default_nettype none

module char_lcd_bus_write_sequencer_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  lcdseq_pkg::req_type                    req_data,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output lcdseq_pkg::rsp_type                    rsp_data,
   input  wire                                    csr_wr_en,
   input  wire  [lcdseq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [lcdseq_pkg::BYTE_W-1:0]          csr_wr_data
);

   lcdseq_pkg::cfg_type        cfg_ff, cfg_in;
   lcdseq_pkg::job_type        push_job;
   lcdseq_pkg::queue_head_type head;
   logic                       push;
   logic                       pop;
   logic                       queue_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lcdseq_pkg::CSR_FOUR_BIT_BUS:     cfg_in.four_bit_bus     = csr_wr_data[0];
            lcdseq_pkg::CSR_FIRST_LINE_BASE:  cfg_in.first_line_base  = csr_wr_data;
            lcdseq_pkg::CSR_SECOND_LINE_BASE: cfg_in.second_line_base = csr_wr_data;
            lcdseq_pkg::CSR_ENABLE_HIGH_MS:   cfg_in.enable_high_ms   = csr_wr_data;
            lcdseq_pkg::CSR_ENABLE_LOW_MS:    cfg_in.enable_low_ms    = csr_wr_data;
            lcdseq_pkg::CSR_DATA_SETUP_MS:    cfg_in.data_setup_ms    = csr_wr_data;
            lcdseq_pkg::CSR_POWER_ON_MS:      cfg_in.power_on_ms      = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.four_bit_bus     <= 1'b1;
         cfg_ff.first_line_base  <= 8'd128;
         cfg_ff.second_line_base <= 8'd192;
         cfg_ff.enable_high_ms   <= 8'd5;
         cfg_ff.enable_low_ms    <= 8'd2;
         cfg_ff.data_setup_ms    <= 8'd50;
         cfg_ff.power_on_ms      <= 8'd40;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcdseq_front u_front (
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   lcdseq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (queue_full),
      .head     (head)
   );

   lcdseq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[verif/lcdseq_phase_monitor.sv]
// watches the lcd sequencer channels, predicts every bus phase and compares the responses
module lcdseq_phase_monitor import lcdseq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wr_data,
   output int                   fail_count,
   output int                   checked_count,
   output int                   pending_phases
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam cfg_type CFG_AT_RESET = {1'b1, 8'd128, 8'd192, 8'd5, 8'd2, 8'd50, 8'd40};

   localparam logic [BYTE_W-1:0] INIT_LIST_EIGHT [3] = '{8'h3C, 8'h0C, 8'h01};
   localparam logic [BYTE_W-1:0] INIT_LIST_FOUR  [4] = '{8'h02, 8'h28, 8'h0C, 8'h06};

   cfg_type shadow_cfg = CFG_AT_RESET;
   rsp_type req_phases[$];
   rsp_type expected_phases[$];
   rsp_type want_phase;

   initial begin
      fail_count     = 0;
      checked_count  = 0;
      pending_phases = 0;
   end

   task report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   task check_field(input string name, input logic [BYTE_W-1:0] got,
                    input logic [BYTE_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("phase %0d %s got 0x%02h want 0x%02h",
                                   checked_count, name, got, want));
   endtask

   function void add_phase(input logic rs, input logic en, input logic [BYTE_W-1:0] bus,
                           input logic [BYTE_W-1:0] hold);
      rsp_type p;
      p            = '0;
      p.reg_select = rs;
      p.enable     = en;
      p.data_bus   = bus;
      p.hold_ms    = hold;
      req_phases.push_back(p);
   endfunction

   function void add_transfer(input logic rs, input logic [BYTE_W-1:0] bus);
      add_phase(rs, 1'b1, bus, shadow_cfg.enable_high_ms);
      add_phase(rs, 1'b0, bus, shadow_cfg.enable_low_ms);
   endfunction

   function void add_byte(input logic rs, input logic [BYTE_W-1:0] b);
      if (shadow_cfg.four_bit_bus) begin
         add_transfer(rs, {4'h0, b[7:4]});
         add_transfer(rs, {4'h0, b[3:0]});
      end else begin
         add_transfer(rs, b);
      end
   endfunction

   function void predict_phases(input req_type r);
      logic [BYTE_W-1:0] addr;
      rsp_type tail;
      req_phases.delete();
      case (r.cmd)
         CMD_BYTE: begin
            add_byte(1'b0, r.byte_value);
         end
         CMD_DATA: begin
            // rs goes high with the setup wait, before the first transfer
            add_phase(1'b1, 1'b0, '0, shadow_cfg.data_setup_ms);
            add_byte(1'b1, r.byte_value);
         end
         CMD_CURSOR: begin
            // wraps at 256, column is not range checked
            addr = (r.row ? shadow_cfg.second_line_base : shadow_cfg.first_line_base)
                   + BYTE_W'(r.column);
            add_byte(1'b0, addr);
         end
         CMD_CLEAR: begin
            add_byte(1'b0, CLEAR_BYTE);
         end
         CMD_INIT: begin
            add_phase(1'b0, 1'b0, '0, shadow_cfg.power_on_ms);
            if (shadow_cfg.four_bit_bus) begin
               foreach (INIT_LIST_FOUR[i]) add_byte(1'b0, INIT_LIST_FOUR[i]);
            end else begin
               foreach (INIT_LIST_EIGHT[i]) add_byte(1'b0, INIT_LIST_EIGHT[i]);
            end
         end
         default: begin
         end
      endcase
      if (req_phases.size() > 0) begin
         tail      = req_phases.pop_back();
         tail.last = 1'b1;
         req_phases.push_back(tail);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         shadow_cfg = CFG_AT_RESET;
         expected_phases.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FOUR_BIT_BUS:     shadow_cfg.four_bit_bus     = csr_wr_data[0];
               CSR_FIRST_LINE_BASE:  shadow_cfg.first_line_base  = csr_wr_data;
               CSR_SECOND_LINE_BASE: shadow_cfg.second_line_base = csr_wr_data;
               CSR_ENABLE_HIGH_MS:   shadow_cfg.enable_high_ms   = csr_wr_data;
               CSR_ENABLE_LOW_MS:    shadow_cfg.enable_low_ms    = csr_wr_data;
               CSR_DATA_SETUP_MS:    shadow_cfg.data_setup_ms    = csr_wr_data;
               CSR_POWER_ON_MS:      shadow_cfg.power_on_ms      = csr_wr_data;
               default: begin
               end
            endcase
         end
         // request first, so a phase leaving at the same edge still finds its expectation
         if (req_valid && !req_stall) begin
            predict_phases(req_data);
            foreach (req_phases[i]) expected_phases.push_back(req_phases[i]);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_phases.size() == 0) begin
               report_mismatch($sformatf("unexpected phase %p", rsp_data));
            end else begin
               want_phase = expected_phases.pop_front();
               check_field("reg_select", BYTE_W'(rsp_data.reg_select),
                           BYTE_W'(want_phase.reg_select));
               check_field("read_write", BYTE_W'(rsp_data.read_write),
                           BYTE_W'(want_phase.read_write));
               check_field("enable", BYTE_W'(rsp_data.enable), BYTE_W'(want_phase.enable));
               check_field("data_bus", rsp_data.data_bus, want_phase.data_bus);
               check_field("hold_ms", rsp_data.hold_ms, want_phase.hold_ms);
               check_field("last", BYTE_W'(rsp_data.last), BYTE_W'(want_phase.last));
            end
            checked_count++;
         end
      end
      pending_phases = expected_phases.size();
   end

endmodule

[verif/testbench.sv]
// top of the lcd sequencer testbench: clock, reset, requests, register writes and verdict
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lcdseq_pkg::*;

   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int SETTLE_CYCLES    = 40;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS     = 400;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED   = 3'd7;
   localparam logic [CMD_W-1:0]     CMD_NOP_LO   = 3'd5;
   localparam logic [CMD_W-1:0]     CMD_NOP_MID  = 3'd6;
   localparam logic [CMD_W-1:0]     CMD_NOP_HI   = 3'd7;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   req_type              req_data    = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [BYTE_W-1:0]    csr_wr_data = '0;

   int  fail_count;
   int  checked_count;
   int  pending_phases;
   int  quiet_cycles = 0;
   bit  req_idle_en  = 1'b1;
   bit  rsp_idle_en  = 1'b1;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   char_lcd_bus_write_sequencer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   lcdseq_phase_monitor phase_mon (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .checked_count  (checked_count),
      .pending_phases (pending_phases)
   );

   function automatic int draw_gap(input bit enabled);
      return enabled ? int'($urandom_range(0, 19)) : 0;
   endfunction

   function automatic req_type make_req(input logic [CMD_W-1:0] cmd,
                                        input logic [BYTE_W-1:0] b, input logic row,
                                        input logic [COLUMN_W-1:0] column);
      req_type r;
      r.cmd        = cmd;
      r.byte_value = b;
      r.row        = row;
      r.column     = column;
      return r;
   endfunction

   function automatic req_type random_req();
      logic [CMD_W-1:0]    cmd;
      logic [COLUMN_W-1:0] column;
      // mostly real requests, a few undefined codes as noise
      if ($urandom_range(0, 9) == 0)
         cmd = CMD_W'($urandom_range(CMD_NOP_LO, CMD_NOP_HI));
      else
         cmd = CMD_W'($urandom_range(CMD_BYTE, CMD_INIT));
      if ($urandom_range(0, 3) == 0)
         column = COLUMN_W'($urandom);
      else
         column = COLUMN_W'($urandom_range(0, 39));
      return make_req(cmd, BYTE_W'($urandom), 1'($urandom), column);
   endfunction

   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return BYTE_W'($urandom);
      endcase
   endfunction

   task automatic send_req(input req_type r);
      int gap;
      gap = draw_gap(req_idle_en);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
   endtask

   task automatic close_csr();
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // wait out every expected phase, then let the bus sit idle before touching registers
   task automatic drain_and_settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_phases != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
   end

   initial begin : receiver
      int hold;
      int taken;
      taken = 0;
      forever begin
         // two long hold-offs let the job queue fill and push back on requests
         if (taken == 150 || taken == 1200)
            hold = LONG_HOLD_CYCLES;
         else
            hold = draw_gap(rsp_idle_en);
         if (hold > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (hold - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin : stimulus
      int      items;
      int      settings;
      int      burst;
      int      requests;
      req_type r;
      items    = 0;
      settings = 1;
      requests = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset settings: four-bit bus
      send_req(make_req(CMD_BYTE, 8'h00, 1'b0, 6'd0));
      send_req(make_req(CMD_BYTE, 8'hFF, 1'b1, 6'd63));
      send_req(make_req(CMD_DATA, 8'h00, 1'b0, 6'd0));
      send_req(make_req(CMD_DATA, 8'hFF, 1'b1, 6'd63));
      send_req(make_req(CMD_CURSOR, 8'h00, 1'b0, 6'd0));
      send_req(make_req(CMD_CURSOR, 8'h00, 1'b1, 6'd39));
      send_req(make_req(CMD_CURSOR, 8'hFF, 1'b1, 6'd63));
      send_req(make_req(CMD_CLEAR, 8'hA5, 1'b0, 6'd21));
      send_req(make_req(CMD_INIT, 8'h5A, 1'b1, 6'd42));
      send_req(make_req(CMD_NOP_LO, 8'hFF, 1'b1, 6'd63));
      send_req(make_req(CMD_NOP_MID, 8'h00, 1'b0, 6'd0));
      send_req(make_req(CMD_NOP_HI, 8'h3C, 1'b0, 6'd5));
      send_req(make_req(CMD_BYTE, 8'hA5, 1'b0, 6'd1));
      requests += 13;
      drain_and_settle();

      // eight-bit bus, extreme bases and hold times, plus a write to an unused index
      write_csr(CSR_FOUR_BIT_BUS, 8'hFE);
      write_csr(CSR_FIRST_LINE_BASE, 8'hFF);
      write_csr(CSR_SECOND_LINE_BASE, 8'h00);
      write_csr(CSR_ENABLE_HIGH_MS, 8'h00);
      write_csr(CSR_ENABLE_LOW_MS, 8'hFF);
      write_csr(CSR_DATA_SETUP_MS, 8'hFF);
      write_csr(CSR_POWER_ON_MS, 8'h00);
      write_csr(CSR_UNUSED, 8'hFF);
      close_csr();
      settings++;
      send_req(make_req(CMD_BYTE, 8'h5A, 1'b0, 6'd0));
      send_req(make_req(CMD_DATA, 8'hFF, 1'b0, 6'd0));
      send_req(make_req(CMD_CURSOR, 8'h00, 1'b0, 6'd63));
      send_req(make_req(CMD_CURSOR, 8'h00, 1'b1, 6'd1));
      send_req(make_req(CMD_CLEAR, 8'h00, 1'b0, 6'd0));
      send_req(make_req(CMD_INIT, 8'h00, 1'b0, 6'd0));
      send_req(make_req(CMD_BYTE, 8'h00, 1'b1, 6'd39));
      requests += 7;
      drain_and_settle();

      while (items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) != 0) write_csr(CSR_FOUR_BIT_BUS, BYTE_W'($urandom));
         if ($urandom_range(0, 1) != 0) write_csr(CSR_FIRST_LINE_BASE, pick_byte());
         if ($urandom_range(0, 1) != 0) write_csr(CSR_SECOND_LINE_BASE, pick_byte());
         if ($urandom_range(0, 1) != 0) write_csr(CSR_ENABLE_HIGH_MS, pick_byte());
         if ($urandom_range(0, 1) != 0) write_csr(CSR_ENABLE_LOW_MS, pick_byte());
         if ($urandom_range(0, 1) != 0) write_csr(CSR_DATA_SETUP_MS, pick_byte());
         if ($urandom_range(0, 1) != 0) write_csr(CSR_POWER_ON_MS, pick_byte());
         close_csr();
         settings++;
         req_idle_en = 1'($urandom_range(0, 2) != 0);
         rsp_idle_en = 1'($urandom_range(0, 2) != 0);
         burst = $urandom_range(30, 60);
         repeat (burst) begin
            r = random_req();
            send_req(r);
            requests++;
            if (r.cmd <= CMD_INIT) items++;
         end
         drain_and_settle();
      end

      $display("run covered %0d requests and %0d bus phases", requests, checked_count);
      $display("over %0d register settings, both bus widths, with stalls on both sides",
               settings);
      if (fail_count == 0 && pending_phases == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[sim.f]
rtl/lcdseq_pkg.sv
rtl/lcdseq_front.sv
rtl/lcdseq_queue.sv
rtl/lcdseq_back.sv
rtl/char_lcd_bus_write_sequencer_core.sv
verif/lcdseq_phase_monitor.sv
verif/testbench.sv
